### src/sdiv128_pkg.sv
// ----------------------------------------------------------------------------
// sdiv128_pkg
// Shared widths, pipeline control type and negation helper for the 128-bit divider.
// ----------------------------------------------------------------------------
package sdiv128_pkg;

  localparam int unsigned HalfW    = 64;
  localparam int unsigned DataW    = 2 * HalfW;
  localparam int unsigned NumSteps = DataW;

  // Control word that travels alongside the data through every stage.
  typedef struct packed {
    logic valid;
    logic dvd_neg;
    logic quo_neg;
    logic dvs_zero;
  } ctl_t;

  // Two's complement negation, wrapping modulo 2^128.
  function automatic logic [DataW-1:0] neg(input logic [DataW-1:0] a);
    return (~a) + {{(DataW-1){1'b0}}, 1'b1};
  endfunction

endpackage

### src/sdiv128_abs.sv
// ----------------------------------------------------------------------------
// sdiv128_abs
// Entry stage: take operand magnitudes and register signs and flags.
// ----------------------------------------------------------------------------
module sdiv128_abs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [sdiv128_pkg::HalfW-1:0]  dividend_hi_i,
  input  logic        [sdiv128_pkg::HalfW-1:0]  dividend_lo_i,
  input  logic signed [sdiv128_pkg::HalfW-1:0]  divisor_hi_i,
  input  logic        [sdiv128_pkg::HalfW-1:0]  divisor_lo_i,
  output sdiv128_pkg::ctl_t                     ctl_o,
  output logic [2*sdiv128_pkg::DataW-1:0]       rq_o,
  output logic [sdiv128_pkg::DataW-1:0]         ds_o
);

  logic [sdiv128_pkg::DataW-1:0] dvd, dvs, dd_mag, ds_mag;
  logic                          dvd_neg, dvs_neg;
  sdiv128_pkg::ctl_t             ctl_d, ctl_q;
  logic [2*sdiv128_pkg::DataW-1:0] rq_d, rq_q;
  logic [sdiv128_pkg::DataW-1:0] ds_d, ds_q;

  always_comb begin
    dvd     = {dividend_hi_i, dividend_lo_i};
    dvs     = {divisor_hi_i, divisor_lo_i};
    dvd_neg = dvd[sdiv128_pkg::DataW-1];
    dvs_neg = dvs[sdiv128_pkg::DataW-1];
    dd_mag  = dvd_neg ? sdiv128_pkg::neg(dvd) : dvd;
    ds_mag  = dvs_neg ? sdiv128_pkg::neg(dvs) : dvs;
    ctl_d.valid    = valid_i;
    ctl_d.dvd_neg  = dvd_neg;
    ctl_d.quo_neg  = dvd_neg ^ dvs_neg;
    ctl_d.dvs_zero = (dvs == '0);
    // Remainder starts empty, dividend magnitude sits in the low half.
    rq_d = {{sdiv128_pkg::DataW{1'b0}}, dd_mag};
    ds_d = ds_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rq_q <= rq_d;
      ds_q <= ds_d;
    end
  end

  assign ctl_o = ctl_q;
  assign rq_o  = rq_q;
  assign ds_o  = ds_q;

endmodule

### src/sdiv128_step.sv
// ----------------------------------------------------------------------------
// sdiv128_step
// One restoring division step: shift, trial subtract, keep or restore.
// ----------------------------------------------------------------------------
module sdiv128_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sdiv128_pkg::ctl_t                     ctl_i,
  input  logic [2*sdiv128_pkg::DataW-1:0]       rq_i,
  input  logic [sdiv128_pkg::DataW-1:0]         ds_i,
  output sdiv128_pkg::ctl_t                     ctl_o,
  output logic [2*sdiv128_pkg::DataW-1:0]       rq_o,
  output logic [sdiv128_pkg::DataW-1:0]         ds_o
);

  localparam int unsigned W = sdiv128_pkg::DataW;

  logic [W:0]       shifted, diff;
  logic             qbit;
  logic [2*W-1:0]   rq_d, rq_q;
  sdiv128_pkg::ctl_t ctl_q;
  logic [W-1:0]     ds_q;

  always_comb begin
    // Partial remainder shifted left with the next dividend bit brought in.
    shifted = rq_i[2*W-1:W-1];
    diff    = shifted - {1'b0, ds_i};
    qbit    = ~diff[W];
    rq_d    = {(qbit ? diff[W-1:0] : shifted[W-1:0]), rq_i[W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rq_q <= rq_d;
      ds_q <= ds_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rq_o  = rq_q;
  assign ds_o  = ds_q;

endmodule

### src/sdiv128_fix.sv
// ----------------------------------------------------------------------------
// sdiv128_fix
// Final stage: apply signs, force zero quotient, drive output register.
// ----------------------------------------------------------------------------
module sdiv128_fix (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  sdiv128_pkg::ctl_t                     ctl_i,
  input  logic [2*sdiv128_pkg::DataW-1:0]       rq_i,
  output logic                                  valid_o,
  output logic signed [sdiv128_pkg::HalfW-1:0]  quotient_hi_o,
  output logic        [sdiv128_pkg::HalfW-1:0]  quotient_lo_o,
  output logic signed [sdiv128_pkg::HalfW-1:0]  remainder_hi_o,
  output logic        [sdiv128_pkg::HalfW-1:0]  remainder_lo_o,
  output logic                                  div_by_zero_o
);

  localparam int unsigned W = sdiv128_pkg::DataW;
  localparam int unsigned H = sdiv128_pkg::HalfW;

  logic [W-1:0] quo_d, rem_d, quo_q, rem_q;
  logic         valid_q, dbz_q;

  always_comb begin
    // With a zero divisor the steps leave the dividend magnitude as remainder.
    if (ctl_i.dvs_zero) begin
      quo_d = '0;
    end else if (ctl_i.quo_neg) begin
      quo_d = sdiv128_pkg::neg(rq_i[W-1:0]);
    end else begin
      quo_d = rq_i[W-1:0];
    end
    rem_d = ctl_i.dvd_neg ? sdiv128_pkg::neg(rq_i[2*W-1:W]) : rq_i[2*W-1:W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      dbz_q <= ctl_i.dvs_zero;
    end
  end

  assign valid_o        = valid_q;
  assign quotient_hi_o  = quo_q[W-1:H];
  assign quotient_lo_o  = quo_q[H-1:0];
  assign remainder_hi_o = rem_q[W-1:H];
  assign remainder_lo_o = rem_q[H-1:0];
  assign div_by_zero_o  = dbz_q;

endmodule

### src/signed_int128_divider_top.sv
// ----------------------------------------------------------------------------
// signed_int128_divider_top
// Fully pipelined signed 128-bit divider with truncating quotient.
// ----------------------------------------------------------------------------
// Each transaction carries a signed 128-bit dividend and divisor, split into a
// signed upper half and an unsigned lower half, and returns the quotient
// rounded toward zero with a remainder that takes the sign of the dividend.
// The pipeline has 130 register stages: one takes the operand magnitudes, 128
// restoring steps each resolve one quotient bit with a 129-bit trial subtract,
// and one applies the signs into the output register. A new transaction may
// enter on every cycle unless the pipeline holds: all stages advance together,
// and when a result waits at the output and out_ready_i is low the whole
// pipeline holds, so nothing is lost or repeated. A zero divisor raises
// div_by_zero_o with a zero quotient and the dividend as remainder. The most
// negative value divided by minus one wraps back to the most negative value
// with a zero remainder.
// ----------------------------------------------------------------------------
module signed_int128_divider_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [sdiv128_pkg::HalfW-1:0]  dividend_hi_i,
  input  logic        [sdiv128_pkg::HalfW-1:0]  dividend_lo_i,
  input  logic signed [sdiv128_pkg::HalfW-1:0]  divisor_hi_i,
  input  logic        [sdiv128_pkg::HalfW-1:0]  divisor_lo_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sdiv128_pkg::HalfW-1:0]  quotient_hi_o,
  output logic        [sdiv128_pkg::HalfW-1:0]  quotient_lo_o,
  output logic signed [sdiv128_pkg::HalfW-1:0]  remainder_hi_o,
  output logic        [sdiv128_pkg::HalfW-1:0]  remainder_lo_o,
  output logic                                  div_by_zero_o
);

  localparam int unsigned W = sdiv128_pkg::DataW;
  localparam int unsigned N = sdiv128_pkg::NumSteps;

  // Stage k feeds step k; stage N feeds the sign fix-up.
  sdiv128_pkg::ctl_t ctl [0:N];
  logic [2*W-1:0]    rq  [0:N];
  logic [W-1:0]      ds  [0:N];
  logic [N:0]        vld_vec;
  logic              adv;

  // Advance everything unless a finished result is still waiting.
  assign adv        = out_ready_i | ~out_valid_o;
  assign in_ready_o = adv;

  sdiv128_abs u_abs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (in_valid_i),
    .dividend_hi_i (dividend_hi_i),
    .dividend_lo_i (dividend_lo_i),
    .divisor_hi_i  (divisor_hi_i),
    .divisor_lo_i  (divisor_lo_i),
    .ctl_o         (ctl[0]),
    .rq_o          (rq[0]),
    .ds_o          (ds[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_step
    sdiv128_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .ctl_i  (ctl[k]),
      .rq_i   (rq[k]),
      .ds_i   (ds[k]),
      .ctl_o  (ctl[k+1]),
      .rq_o   (rq[k+1]),
      .ds_o   (ds[k+1])
    );
  end

  for (genvar k = 0; k <= N; k++) begin : g_vld
    assign vld_vec[k] = ctl[k].valid;
  end

  sdiv128_fix u_fix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .ctl_i          (ctl[N]),
    .rq_i           (rq[N]),
    .valid_o        (out_valid_o),
    .quotient_hi_o  (quotient_hi_o),
    .quotient_lo_o  (quotient_lo_o),
    .remainder_hi_o (remainder_hi_o),
    .remainder_lo_o (remainder_lo_o),
    .div_by_zero_o  (div_by_zero_o)
  );

  // Hold every stage's occupancy while the output is blocked.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_vec))
    else $error("pipeline occupancy changed during a stall");

  // Zero flag in the first stage must match the stored divisor magnitude.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl[0].valid |-> (ctl[0].dvs_zero == (ds[0] == '0)))
    else $error("divisor zero flag disagrees with divisor magnitude");

  // After the last step the remainder magnitude lies below the divisor.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl[N].valid && !ctl[N].dvs_zero) |-> (rq[N][2*W-1:W] < ds[N]))
    else $error("final remainder not below divisor");

  // A zero divisor always yields a zero quotient.
  a_dbz_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_by_zero_o) |-> (quotient_hi_o == '0 && quotient_lo_o == '0))
    else $error("non-zero quotient with zero divisor");

endmodule

### bench/tb_signed_int128_divider_top.sv
// ----------------------------------------------------------------------------
// tb_signed_int128_divider_top
// Self-checking bench for the pipelined signed 128-bit divider.
// ----------------------------------------------------------------------------
// Every division handed to the block is also worked out here on whole 128-bit
// values, and the answer is queued. Each transaction that leaves the block is
// compared field by field against the oldest queued answer. Both handshakes
// idle at random, apart from one burst run flat out and one pause in which
// the pipeline drains completely. The stimulus opens with corner divisions,
// then moves on to random operands drawn from several magnitude classes.
// ----------------------------------------------------------------------------
module tb_signed_int128_divider_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      HalfW    = sdiv128_pkg::HalfW;
  localparam int unsigned      DataW    = sdiv128_pkg::DataW;

  localparam logic [DataW-1:0] MostNeg  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] MostPos  = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] MinusOne = '1;
  localparam logic [DataW-1:0] One      = 128'd1;
  localparam int unsigned      IdlePct  = 26;
  // The pipeline is 130 stages deep; wait a little beyond that at the end.
  localparam int unsigned      DrainCycles = 150;
  // Longest legal quiet spell is a full drain plus a run of output stalls.
  localparam int unsigned      StallLimit  = 5000;

  // One expected result: quotient, remainder and the zero-divisor flag.
  typedef struct packed {
    logic [HalfW-1:0] quo_hi;
    logic [HalfW-1:0] quo_lo;
    logic [HalfW-1:0] rem_hi;
    logic [HalfW-1:0] rem_lo;
    logic             dbz;
  } division_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [HalfW-1:0] dividend_hi_i;
  logic        [HalfW-1:0] dividend_lo_i;
  logic signed [HalfW-1:0] divisor_hi_i;
  logic        [HalfW-1:0] divisor_lo_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [HalfW-1:0] quotient_hi_o;
  logic        [HalfW-1:0] quotient_lo_o;
  logic signed [HalfW-1:0] remainder_hi_o;
  logic        [HalfW-1:0] remainder_lo_o;
  logic                    div_by_zero_o;

  division_t   pending_divisions[$];
  bit          steady_flow;
  int unsigned divisions_sent;
  int unsigned results_checked;
  int unsigned zero_divisors;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  signed_int128_divider_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .dividend_hi_i  (dividend_hi_i),
    .dividend_lo_i  (dividend_lo_i),
    .divisor_hi_i   (divisor_hi_i),
    .divisor_lo_i   (divisor_lo_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .quotient_hi_o  (quotient_hi_o),
    .quotient_lo_o  (quotient_lo_o),
    .remainder_hi_o (remainder_hi_o),
    .remainder_lo_o (remainder_lo_o),
    .div_by_zero_o  (div_by_zero_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Work out the division on full 128-bit values: divide the magnitudes
  // unsigned, then negate the quotient when the signs differ and give the
  // remainder the sign of the dividend. Negation wraps, so the most negative
  // value divided by minus one comes back as itself.
  function automatic division_t predict_division(input logic [DataW-1:0] dvd,
                                                 input logic [DataW-1:0] dvs);
    logic [DataW-1:0] mag_dvd;
    logic [DataW-1:0] mag_dvs;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
    division_t        res;
    if (dvs == '0) begin
      quo = '0;
      rem = dvd;
      res.dbz = 1'b1;
    end else begin
      mag_dvd = dvd[DataW-1] ? (~dvd + One) : dvd;
      mag_dvs = dvs[DataW-1] ? (~dvs + One) : dvs;
      quo = mag_dvd / mag_dvs;
      rem = mag_dvd % mag_dvs;
      if (dvd[DataW-1] != dvs[DataW-1]) quo = ~quo + One;
      if (dvd[DataW-1]) rem = ~rem + One;
      res.dbz = 1'b0;
    end
    res.quo_hi = quo[DataW-1:HalfW];
    res.quo_lo = quo[HalfW-1:0];
    res.rem_hi = rem[DataW-1:HalfW];
    res.rem_lo = rem[HalfW-1:0];
    return res;
  endfunction

  // Hand one division to the block; return at the edge that accepts it.
  task automatic send_division(input logic [DataW-1:0] dvd,
                               input logic [DataW-1:0] dvs);
    while (!steady_flow && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    dividend_hi_i <= dvd[DataW-1:HalfW];
    dividend_lo_i <= dvd[HalfW-1:0];
    divisor_hi_i  <= dvs[DataW-1:HalfW];
    divisor_lo_i  <= dvs[HalfW-1:0];
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    divisions_sent++;
    if (dvs == '0) zero_divisors++;
  endtask

  // Draw an operand from one of several classes so that small, huge, sign
  // boundary and power-of-two magnitudes all turn up regularly.
  function automatic logic [DataW-1:0] random_operand();
    logic [DataW-1:0] val;
    val = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: val = {{(DataW-16){val[15]}}, val[15:0]};
      1: val = {{HalfW{val[HalfW-1]}}, val[HalfW-1:0]};
      2: begin
        val = One << $urandom_range(0, DataW - 1);
        if ($urandom_range(0, 1)) val = ~val + One;
      end
      3: case ($urandom_range(0, 4))
        0: val = MostNeg;
        1: val = MostPos;
        2: val = MinusOne;
        3: val = One;
        default: val = MostNeg + One;
      endcase
      4: val[HalfW-1:0] = $urandom_range(0, 1) ? '1 : '0;
      5: val = {{(DataW-40){val[39]}}, val[39:0]};
      default: ;
    endcase
    return val;
  endfunction

  task automatic send_random_divisions(input int unsigned count);
    logic [DataW-1:0] dvd;
    logic [DataW-1:0] dvs;
    repeat (count) begin
      dvd = random_operand();
      dvs = ($urandom_range(0, 99) < 3) ? '0 : random_operand();
      send_division(dvd, dvs);
    end
  endtask

  // Extremes of each half, every sign pairing, and the zero divisor and
  // most-negative-by-minus-one special cases.
  task automatic test_corner_divisions();
    send_division(128'd0, One);
    send_division(One, One);
    send_division(128'd7, 128'd2);
    send_division(-128'd7, 128'd2);
    send_division(128'd7, -128'd2);
    send_division(-128'd7, -128'd2);
    send_division(MostNeg, MinusOne);
    send_division(MostNeg, One);
    send_division(MostNeg, MostNeg);
    send_division(MostPos, MostNeg);
    send_division(MostNeg, MostPos);
    send_division(MostPos, One);
    send_division(MostPos, MinusOne);
    send_division(One, MostPos);
    send_division(128'd0, 128'd0);
    send_division(MostNeg, 128'd0);
    send_division(MostPos, 128'd0);
    send_division(MinusOne, 128'd0);
    send_division(MostPos, {{HalfW{1'b0}}, {HalfW{1'b1}}});
    send_division({{HalfW{1'b1}}, {HalfW{1'b0}}}, {{(HalfW-1){1'b0}}, 1'b1, {HalfW{1'b0}}});
    send_division({$urandom, $urandom, $urandom, $urandom}, MostNeg + One);
    send_division(MinusOne, MostNeg);
  endtask

  // Mixed operands with random idling on both sides.
  task automatic test_random_divisions();
    send_random_divisions(700);
  endtask

  // Back-to-back transactions with no gaps and no stalls.
  task automatic test_full_rate_burst();
    steady_flow = 1'b1;
    send_random_divisions(300);
    steady_flow = 1'b0;
  endtask

  // Let the pipeline empty completely mid-run, then refill it.
  task automatic test_drain_and_refill();
    send_random_divisions(60);
    in_valid_i <= 1'b0;
    while (pending_divisions.size() != 0) @(posedge clk_i);
    send_random_divisions(60);
  endtask

  task automatic test_random_tail();
    send_random_divisions(360);
  endtask

  // Receiver: stall at random except during the full-rate burst.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(0, 99) >= IdlePct);
  end

  task automatic compare_field(input string name, input logic [HalfW-1:0] exp_val,
                               input logic [HalfW-1:0] act_val, inout bit bad);
    if (exp_val !== act_val) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_val, act_val);
      bad = 1'b1;
    end
  endtask

  // Queue the answer for each accepted division and check each result
  // transaction against the oldest one. Inputs are handled first so the
  // ordering holds whatever the latency.
  always @(posedge clk_i) begin
    division_t exp_res;
    bit        bad;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_divisions.push_back(predict_division({dividend_hi_i, dividend_lo_i},
                                                     {divisor_hi_i, divisor_lo_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_divisions.size() == 0) begin
          $display("%0t: result with nothing outstanding, quotient %h%h", $time,
                   quotient_hi_o, quotient_lo_o);
          mismatches++;
        end else begin
          exp_res = pending_divisions.pop_front();
          bad = 1'b0;
          compare_field("quotient_hi", exp_res.quo_hi, quotient_hi_o, bad);
          compare_field("quotient_lo", exp_res.quo_lo, quotient_lo_o, bad);
          compare_field("remainder_hi", exp_res.rem_hi, remainder_hi_o, bad);
          compare_field("remainder_lo", exp_res.rem_lo, remainder_lo_o, bad);
          compare_field("div_by_zero", {{(HalfW-1){1'b0}}, exp_res.dbz},
                        {{(HalfW-1){1'b0}}, div_by_zero_o}, bad);
          if (bad) mismatches++;
          results_checked++;
        end
      end
    end
  end

  // Watchdog: give up once no transaction has moved for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    steady_flow     = 1'b0;
    divisions_sent  = 0;
    zero_divisors   = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    dividend_hi_i <= '0;
    dividend_lo_i <= '0;
    divisor_hi_i  <= '0;
    divisor_lo_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_divisions();
    test_random_divisions();
    test_full_rate_burst();
    test_drain_and_refill();
    test_random_tail();

    // Drop valid, wait for every answer, then watch for stray results.
    in_valid_i <= 1'b0;
    while (pending_divisions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Divided %0d operand pairs (%0d by zero), checked %0d results.",
             divisions_sent, zero_divisors, results_checked);
    $display("Covered corners, mixed magnitudes, a full-rate burst and a drain.");
    if (mismatches == 0 && pending_divisions.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
